[design/mtbd_pkg.sv]
// Package: constants and command/status types for the bounded MT19937 draw.
`timescale 1ns / 1ps
`default_nettype none
package mtbd_pkg;
  localparam int unsigned StateWords  = 624;
  localparam int unsigned TwistOffset = 397;
  localparam int unsigned IdxW        = 10;
  localparam int unsigned AddrW       = 10;
  localparam logic [31:0] MatrixA     = 32'h9908b0df;
  localparam logic [31:0] SeedMult    = 32'd69069;
  localparam logic [31:0] DefaultSeed = 32'd4357;

  typedef struct packed {
    logic seed_start;
    logic twist_start;
    logic draw_start;
    logic rem_start;
  } mtbd_cmd_t;

  typedef struct packed {
    logic seed_done;
    logic twist_done;
    logic draw_done;
    logic rem_done;
  } mtbd_sts_t;
endpackage
`default_nettype wire

[design/mtbd_datapath.sv]
// Datapath: state table memory, seeding, twist, tempering and serial remainder.
`timescale 1ns / 1ps
`default_nettype none
module mtbd_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mtbd_pkg::mtbd_cmd_t cmd_i,
  output mtbd_pkg::mtbd_sts_t     sts_o,
  input  wire logic [31:0]        seed_i,
  input  wire logic [31:0]        bound_i,
  input  wire logic [9:0]         index_i,
  output logic [31:0]             value_o
);
  import mtbd_pkg::*;

  localparam logic [2:0] OpIdle  = 3'd0;
  localparam logic [2:0] OpSeed  = 3'd1;
  localparam logic [2:0] OpTwA   = 3'd2;
  localparam logic [2:0] OpTwB   = 3'd3;
  localparam logic [2:0] OpDrawR = 3'd4;
  localparam logic [2:0] OpDrawT = 3'd5;
  localparam logic [2:0] OpRem   = 3'd6;
  localparam logic [2:0] OpTwC   = 3'd7;

  logic [31:0] mem_q [StateWords];
  logic [2:0]  op_q;
  logic [AddrW-1:0] k_q, nxt_q, far_q;
  logic [31:0] prev_q, cur_q, nx_q, rd_q;
  logic [31:0] rem_q, quo_q, den_q;
  logic [5:0]  cnt_q;
  logic        seed_done_q, twist_done_q, draw_done_q, rem_done_q;
  logic [31:0] twist_w, y_w, t1, t2, t3, t4;
  logic [32:0] rem_sh;
  logic [AddrW-1:0] k_inc, nxt_inc, far_inc;

  assign k_inc   = (k_q == AddrW'(StateWords - 1)) ? '0 : k_q + 1'b1;
  assign nxt_inc = (nxt_q == AddrW'(StateWords - 1)) ? '0 : nxt_q + 1'b1;
  assign far_inc = (far_q == AddrW'(StateWords - 1)) ? '0 : far_q + 1'b1;

  // nx_q holds table[k+1] read last step; rd_q holds table[far].
  assign y_w = {cur_q[31], nx_q[30:0]};
  assign twist_w = rd_q ^ (y_w >> 1) ^ (y_w[0] ? MatrixA : 32'h0);

  assign t1 = rd_q ^ (rd_q >> 11);
  assign t2 = t1 ^ ((t1 << 7) & 32'h9d2c5680);
  assign t3 = t2 ^ ((t2 << 15) & 32'hefc60000);
  assign t4 = t3 ^ (t3 >> 18);

  assign rem_sh = {rem_q, quo_q[31]};

  always_ff @(posedge clk_i) begin
    case (op_q)
      OpSeed: mem_q[k_q] <= prev_q;
      OpTwB:  mem_q[k_q] <= twist_w;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (op_q)
      OpTwA:   begin cur_q <= mem_q[k_q]; nx_q <= mem_q[nxt_q]; end
      OpTwC:   rd_q <= mem_q[far_q];
      OpTwB:   begin
        // new word written at k; next step's cur is old table[k+1]
        cur_q <= nx_q;
        nx_q <= mem_q[nxt_inc]; rd_q <= mem_q[far_inc];
      end
      OpDrawR: rd_q <= mem_q[index_i];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OpIdle;
      seed_done_q <= 1'b0; twist_done_q <= 1'b0;
      draw_done_q <= 1'b0; rem_done_q <= 1'b0;
      k_q <= '0; nxt_q <= '0; far_q <= '0; cnt_q <= '0;
    end else begin
      seed_done_q <= 1'b0; twist_done_q <= 1'b0;
      draw_done_q <= 1'b0; rem_done_q <= 1'b0;
      case (op_q)
        OpIdle: begin
          if (cmd_i.seed_start) begin
            op_q <= OpSeed; k_q <= '0;
          end else if (cmd_i.twist_start) begin
            op_q <= OpTwA; k_q <= '0;
            nxt_q <= AddrW'(1); far_q <= AddrW'(TwistOffset);
          end else if (cmd_i.draw_start) begin
            op_q <= OpDrawR;
          end else if (cmd_i.rem_start) begin
            op_q <= OpRem; cnt_q <= '0;
          end
        end
        OpSeed: begin
          if (k_q == AddrW'(StateWords - 1)) begin
            op_q <= OpIdle; seed_done_q <= 1'b1;
          end
          k_q <= k_inc;
        end
        OpTwA: op_q <= OpTwC;
        OpTwC: op_q <= OpTwB;
        OpTwB: begin
          nxt_q <= nxt_inc; far_q <= far_inc;
          if (k_q == AddrW'(StateWords - 1)) begin
            op_q <= OpIdle; twist_done_q <= 1'b1;
          end
          k_q <= k_inc;
        end
        OpDrawR: op_q <= OpDrawT;
        OpDrawT: begin
          op_q <= OpIdle; draw_done_q <= 1'b1;
        end
        OpRem: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'd31) begin
            op_q <= OpIdle; rem_done_q <= 1'b1;
          end
        end
        default: op_q <= OpIdle;
      endcase
    end
  end

  // Seed chain and remainder registers.
  always_ff @(posedge clk_i) begin
    if (op_q == OpIdle && cmd_i.seed_start) prev_q <= seed_i;
    else if (op_q == OpSeed) prev_q <= prev_q * SeedMult;
    if (op_q == OpDrawT) begin
      quo_q <= t4; rem_q <= '0; den_q <= bound_i;
    end else if (op_q == OpRem) begin
      quo_q <= {quo_q[30:0], 1'b0};
      if (rem_sh >= {1'b0, den_q}) rem_q <= 32'(rem_sh - {1'b0, den_q});
      else rem_q <= rem_sh[31:0];
    end
  end

  assign sts_o.seed_done  = seed_done_q;
  assign sts_o.twist_done = twist_done_q;
  assign sts_o.draw_done  = draw_done_q;
  assign sts_o.rem_done   = rem_done_q;
  assign value_o = rem_q;
endmodule
`default_nettype wire

[design/mtbd_ctrl.sv]
// Controller: sequences seeding, twisting, drawing and reduction per word.
`timescale 1ns / 1ps
`default_nettype none
module mtbd_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [31:0]        bound_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [31:0]        cfg_data_i,
  output logic [31:0]             value_o,
  output mtbd_pkg::mtbd_cmd_t     cmd_o,
  input  wire mtbd_pkg::mtbd_sts_t sts_i,
  input  wire logic [31:0]        dp_value_i,
  output logic [31:0]             seed_o,
  output logic [31:0]             bound_o,
  output logic [9:0]              index_o
);
  import mtbd_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSeed  = 3'd1;
  localparam logic [2:0] StTwist = 3'd2;
  localparam logic [2:0] StDraw  = 3'd3;
  localparam logic [2:0] StRem   = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0]      st_q;
  logic [31:0]     seed_q, bound_q, value_q;
  logic [IdxW-1:0] idx_q;
  logic            accept;

  assign in_ready_o  = (st_q == StIdle) && !cfg_valid_i;
  assign cfg_ready_o = (st_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (st_q == StOut);
  assign value_o     = value_q;
  assign seed_o      = seed_q;
  assign bound_o     = bound_q;
  assign index_o     = idx_q;

  always_comb begin
    cmd_o = '0;
    if (st_q == StIdle && accept && bound_i != 32'h0) begin
      if (idx_q == IdxW'(StateWords + 1)) cmd_o.seed_start = 1'b1;
      else if (idx_q == IdxW'(StateWords)) cmd_o.twist_start = 1'b1;
      else cmd_o.draw_start = 1'b1;
    end
    if (st_q == StSeed && sts_i.seed_done) cmd_o.twist_start = 1'b1;
    if (st_q == StTwist && sts_i.twist_done) cmd_o.draw_start = 1'b1;
    if (st_q == StDraw && sts_i.draw_done) cmd_o.rem_start = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      seed_q <= DefaultSeed;
      idx_q  <= IdxW'(StateWords + 1);
    end else begin
      case (st_q)
        StIdle: begin
          if (cfg_valid_i) begin
            seed_q <= cfg_data_i;
            idx_q  <= IdxW'(StateWords + 1);
          end else if (accept) begin
            bound_q <= bound_i;
            if (bound_i == 32'h0) begin
              value_q <= '0; st_q <= StOut;
            end else if (idx_q == IdxW'(StateWords + 1)) st_q <= StSeed;
            else if (idx_q == IdxW'(StateWords)) st_q <= StTwist;
            else st_q <= StDraw;
          end
        end
        StSeed:  if (sts_i.seed_done) st_q <= StTwist;
        StTwist: if (sts_i.twist_done) begin
          idx_q <= '0; st_q <= StDraw;
        end
        StDraw:  if (sts_i.draw_done) begin
          idx_q <= idx_q + 1'b1; st_q <= StRem;
        end
        StRem:   if (sts_i.rem_done) begin
          value_q <= dp_value_i; st_q <= StOut;
        end
        StOut:   if (out_ready_i) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

[design/mersenne_twister_bounded_draw.sv]
// Top level: bounded MT19937 draw, controller plus datapath.
// An accepted bound first waits for a seeding pass and a twist pass on the first draw
// after seeding, and for a twist pass after every 624 draws; the 32-step serial remainder
// sets the pace, and a new bound is taken only once the previous word is handed over.
// Zero bound: word valid in the cycle after accept. Reset: table unseeded, seed 4357.
`timescale 1ns / 1ps
`default_nettype none
module mersenne_twister_bounded_draw (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] bound_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      value_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i
);
  import mtbd_pkg::*;

  mtbd_cmd_t   cmd;
  mtbd_sts_t   sts;
  logic [31:0] seed, bound, dp_value;
  logic [9:0]  index;

  mtbd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .bound_i,
    .out_valid_o, .out_ready_i, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .value_o, .cmd_o(cmd), .sts_i(sts), .dp_value_i(dp_value),
    .seed_o(seed), .bound_o(bound), .index_o(index)
  );

  mtbd_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .seed_i(seed),
    .bound_i(bound), .index_i(index), .value_o(dp_value)
  );
endmodule
`default_nettype wire

[sim/testbench.sv]
// Testbench for the bounded MT19937 draw: self-checking against an in-bench twister model.
`timescale 1ns / 1ps
module testbench;
  import mtbd_pkg::*;

  localparam int unsigned Unseeded = StateWords + 1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] bound_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] value_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  logic [31:0] mt_words [StateWords];
  int unsigned word_pos;
  logic [31:0] cur_seed;
  logic [31:0] pending_values [$];

  int   mismatches;
  int   words_sent;
  int   words_checked;
  int   seeds_written;
  int   hold_cycles;
  bit   quiet;

  mersenne_twister_bounded_draw dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .bound_i    (bound_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_o    (value_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [31:0] temper_word(logic [31:0] y);
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9d2c5680);
    y = y ^ ((y << 15) & 32'hefc60000);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic void regenerate_words();
    int unsigned nxt;
    int unsigned far;
    logic [31:0] y;
    logic [31:0] w;
    for (int unsigned k = 0; k < StateWords; k++) begin
      nxt = (k + 1) % StateWords;
      far = (k + TwistOffset) % StateWords;
      y = (mt_words[k] & 32'h80000000) | (mt_words[nxt] & 32'h7fffffff);
      w = mt_words[far] ^ (y >> 1);
      if (y[0]) begin
        w = w ^ MatrixA;
      end
      mt_words[k] = w;
    end
  endfunction

  function automatic logic [31:0] predict_draw(logic [31:0] bound);
    logic [31:0] y;
    if (bound == 0) begin
      return '0;
    end
    if (word_pos >= StateWords) begin
      if (word_pos != StateWords) begin
        mt_words[0] = cur_seed;
        for (int unsigned i = 1; i < StateWords; i++) begin
          mt_words[i] = mt_words[i - 1] * SeedMult;
        end
      end
      regenerate_words();
      word_pos = 0;
    end
    y = temper_word(mt_words[word_pos]);
    word_pos++;
    return y % bound;
  endfunction

  function automatic logic [31:0] random_bound();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) begin
      return '0;
    end else if (pick < 35) begin
      return $urandom_range(40, 1);
    end else if (pick < 50) begin
      return 32'h1 << $urandom_range(31);
    end else begin
      return $urandom;
    end
  endfunction

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (quiet) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= 24);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_values.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual value=%0h", $time, value_o);
        mismatches++;
      end else begin
        if (value_o !== pending_values[0]) begin
          $display("%0t: value mismatch, expected %0h, actual %0h", $time,
                   pending_values[0], value_o);
          mismatches++;
        end
        void'(pending_values.pop_front());
        words_checked++;
      end
    end
  end

  task automatic send_bound(logic [31:0] bound);
    in_valid_i <= 1'b1;
    bound_i    <= bound;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    pending_values.push_back(predict_draw(bound));
    words_sent++;
    if (!quiet && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_values.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_seed(logic [31:0] s);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= s;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    cur_seed = s;
    word_pos = Unseeded;
    seeds_written++;
  endtask

  task automatic test_directed_bounds();
    logic [31:0] bounds [12] = '{32'h0, 32'h1, 32'h2, 32'hffffffff, 32'h0, 32'h80000000,
                                 32'h7fffffff, 32'h3, 32'h0, 32'h55555555, 32'haaaaaaaa, 32'h7};
    foreach (bounds[i]) begin
      send_bound(bounds[i]);
    end
    stop_sending();
  endtask

  task automatic test_seed_extremes();
    logic [31:0] seeds [4] = '{32'h0, 32'hffffffff, 32'hffffffff, DefaultSeed};
    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      repeat (3) send_bound(random_bound() | 32'h1);
      send_bound(32'h0);
      stop_sending();
    end
  endtask

  task automatic test_backpressure();
    quiet = 1'b1;
    hold_cycles = 400;
    repeat (40) send_bound(random_bound());
    stop_sending();
    wait_drained();
    quiet = 1'b0;
  endtask

  task automatic test_random_phase(int unsigned count, logic [31:0] s, bit calm);
    write_seed(s);
    quiet = calm;
    repeat (count) send_bound(random_bound());
    stop_sending();
    quiet = 1'b0;
  endtask

  initial begin
    mismatches = 0;
    words_sent = 0;
    words_checked = 0;
    seeds_written = 0;
    hold_cycles = 0;
    quiet = 1'b0;
    cur_seed = DefaultSeed;
    word_pos = Unseeded;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_bounds();
    test_seed_extremes();
    test_backpressure();
    test_random_phase(700, $urandom, 1'b0);
    test_random_phase(200, $urandom, 1'b1);
    test_random_phase(200, 32'h0, 1'b0);
    test_random_phase(200, $urandom, 1'b0);
    wait_drained();
    $display("Covered %0d draws (%0d checked) over %0d seed writes, incl. twist rollover,",
             words_sent, words_checked, seeds_written);
    $display("zero bounds, full-range bounds and a long output stall.");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d words outstanding", pending_values.size());
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

[filelist.f]
design/mtbd_pkg.sv
design/mtbd_datapath.sv
design/mtbd_ctrl.sv
design/mersenne_twister_bounded_draw.sv
sim/testbench.sv
